[rtl/plcd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// plcd_pkg
// Shared types, constants and the CRC byte function of the payload CRC-32
// and lane digest block.
// ----------------------------------------------------------------------------
package plcd_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  localparam logic [63:0] LANE_INIT0 = 64'h243F6A8885A308D3;
  localparam logic [63:0] LANE_INIT1 = 64'h13198A2E03707344;
  localparam logic [63:0] LANE_INIT2 = 64'hA4093822299F31D0;
  localparam logic [63:0] LANE_INIT3 = 64'h082EFA98EC4E6C89;
  localparam logic [3:0][63:0] LANE_INIT = {LANE_INIT3, LANE_INIT2, LANE_INIT1, LANE_INIT0};

  localparam logic [63:0] MIX_ADD = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] FIN_MUL = 64'hC4CEB9FE1A85EC53;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last;
    logic [31:0] crc;       // final CRC, meaningful when last is set
  } qent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_XOR,
    ST_MUL,
    ST_MIX,
    ST_FXOR,
    ST_OUT
  } st_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/payload_crc32_and_lane_digest.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// payload_crc32_and_lane_digest
// Byte-stream CRC-32 and four-lane 256-bit digest.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one payload byte per transfer, with
// in_has_byte marking a real byte and in_last closing the message. The front
// end takes a transfer every cycle while its four-entry queue has room; the
// CRC is updated there in the same cycle.
// Result channel (out_valid/out_ready): four transfers per message, digest
// words 0 to 3, each with the final CRC; out_last_word marks the fourth.
// Throughput is set by the back end, which shares one 32x32 multiplier
// and works on one payload byte at a time: sum, xor, multiply, mix,
// dispatch. Closing a message adds the two finalization rounds (8 lane
// updates) and the four result words.
// Items with neither a byte nor last are dropped at the front end.
// A stalled receiver holds the output register and, while result words
// remain, the back end; the front end keeps taking transfers until the
// queue fills. Reset (rst_n low, synchronous) clears the queue, restarts
// the CRC and loads the lane constants and a zero byte count.
// ----------------------------------------------------------------------------
module payload_crc32_and_lane_digest (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_digest_word,
  output logic [1:0]       out_word_index,
  output logic [31:0]      out_crc_value,
  output logic             out_last_word
);

  plcd_pkg::qent_t push_data;
  plcd_pkg::qent_t pop_data;
  logic q_push, q_full, q_pop, q_empty;

  plcd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_has_byte  (in_has_byte),
    .in_last      (in_last),
    .q_push       (q_push),
    .q_data       (push_data),
    .q_full       (q_full)
  );

  plcd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  plcd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_pop           (q_pop),
    .q_data          (pop_data),
    .q_empty         (q_empty),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_crc_value   (out_crc_value),
    .out_last_word   (out_last_word)
  );

endmodule
`default_nettype wire

[rtl/plcd_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// plcd_queue
// Short first-in first-out queue of classified items between the front and
// the back of the digest block.
// ----------------------------------------------------------------------------
module plcd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire plcd_pkg::qent_t push_data,
  output logic                full,
  input  wire logic           pop,
  output plcd_pkg::qent_t     pop_data,
  output logic                empty
);

  plcd_pkg::qent_t [plcd_pkg::QDEPTH-1:0] mem_r;
  logic [plcd_pkg::QAW-1:0] wptr_r, wptr_nxt;
  logic [plcd_pkg::QAW-1:0] rptr_r, rptr_nxt;
  logic [plcd_pkg::QCW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full     = (cnt_r == plcd_pkg::QCW'(plcd_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

[rtl/plcd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// plcd_front
// Input side: takes one item per cycle while the queue has room, runs the
// CRC-32 byte update, drops items with no byte and no last, queues the rest.
// ----------------------------------------------------------------------------
module plcd_front (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_has_byte,
  input  wire logic       in_last,
  output logic            q_push,
  output plcd_pkg::qent_t q_data,
  input  wire logic       q_full
);

  logic [31:0] crc_r, crc_nxt;
  logic [31:0] crc_upd;
  logic        xfer;

  assign in_ready = !q_full;
  assign xfer     = in_valid && in_ready;
  assign crc_upd  = in_has_byte ? plcd_pkg::crc_byte(crc_r, in_data_byte) : crc_r;

  always_comb begin
    q_push           = xfer && (in_has_byte || in_last);
    q_data.data_byte = in_data_byte;
    q_data.has_byte  = in_has_byte;
    q_data.last      = in_last;
    q_data.crc       = ~crc_upd;
    crc_nxt          = crc_r;
    if (xfer) begin
      // restart the CRC once a message closes
      crc_nxt = in_last ? plcd_pkg::CRC_ONES : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= plcd_pkg::CRC_ONES;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/plcd_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// plcd_back
// Digest engine: mixes queued bytes into the four lanes through one shared
// 32x32 multiplier, runs the two finalization rounds and drives the result
// register.
// ----------------------------------------------------------------------------
module plcd_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  output logic             q_pop,
  input  wire plcd_pkg::qent_t q_data,
  input  wire logic        q_empty,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_digest_word,
  output logic [1:0]       out_word_index,
  output logic [31:0]      out_crc_value,
  output logic             out_last_word
);

  plcd_pkg::st_t state_r, state_nxt;

  logic [3:0][63:0] lanes_r, lanes_nxt;
  logic [63:0]      count_r, count_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [63:0]      x_r, x_nxt;
  logic [63:0]      prod_r, prod_nxt;
  logic [1:0]       mul_cnt_r, mul_cnt_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic             round_r, round_nxt;
  logic             fin_r, fin_nxt;
  logic             last_r, last_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [31:0]      crc_r, crc_nxt;

  logic             ov_r, ov_nxt;
  logic [63:0]      ow_r, ow_nxt;
  logic [1:0]       oi_r, oi_nxt;
  logic [31:0]      oc_r, oc_nxt;
  logic             ol_r, ol_nxt;

  logic [63:0] mconst;
  logic [31:0] opa, opb;
  logic [63:0] lane_sel;
  logic [63:0] mixed;

  assign mconst   = fin_r ? plcd_pkg::FIN_MUL : plcd_pkg::MIX_MUL;
  assign opa      = (mul_cnt_r == 2'd2) ? x_r[63:32] : x_r[31:0];
  assign opb      = (mul_cnt_r == 2'd1) ? mconst[63:32] : mconst[31:0];
  assign lane_sel = lanes_r[idx_r];
  assign mixed    = fin_r ? (acc_r ^ (acc_r >> 29)) : (acc_r ^ (acc_r >> 33));

  assign out_valid       = ov_r;
  assign out_digest_word = ow_r;
  assign out_word_index  = oi_r;
  assign out_crc_value   = oc_r;
  assign out_last_word   = ol_r;

  always_comb begin
    state_nxt   = state_r;
    lanes_nxt   = lanes_r;
    count_nxt   = count_r;
    acc_nxt     = acc_r;
    x_nxt       = x_r;
    prod_nxt    = {32'd0, opa} * {32'd0, opb};
    mul_cnt_nxt = mul_cnt_r;
    idx_nxt     = idx_r;
    round_nxt   = round_r;
    fin_nxt     = fin_r;
    last_nxt    = last_r;
    byte_nxt    = byte_r;
    crc_nxt     = crc_r;
    q_pop       = 1'b0;
    ov_nxt      = ov_r && !out_ready;
    ow_nxt      = ow_r;
    oi_nxt      = oi_r;
    oc_nxt      = oc_r;
    ol_nxt      = ol_r;

    case (state_r)
      plcd_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          byte_nxt = q_data.data_byte;
          last_nxt = q_data.last;
          crc_nxt  = q_data.crc;
          round_nxt = 1'b0;
          if (q_data.has_byte) begin
            idx_nxt   = count_r[1:0];
            fin_nxt   = 1'b0;
            state_nxt = plcd_pkg::ST_SUM;
          end else begin
            // close-only item: go straight to finalization
            idx_nxt   = 2'd0;
            fin_nxt   = 1'b1;
            state_nxt = plcd_pkg::ST_FXOR;
          end
        end
      end

      plcd_pkg::ST_SUM: begin
        acc_nxt   = (lane_sel << 6) + (lane_sel >> 2);
        state_nxt = plcd_pkg::ST_XOR;
      end

      plcd_pkg::ST_XOR: begin
        x_nxt       = lane_sel ^ (acc_r + {56'd0, byte_r} + plcd_pkg::MIX_ADD);
        mul_cnt_nxt = 2'd0;
        state_nxt   = plcd_pkg::ST_MUL;
      end

      plcd_pkg::ST_FXOR: begin
        x_nxt       = lane_sel ^ lanes_r[idx_r + 2'd1];
        mul_cnt_nxt = 2'd0;
        state_nxt   = plcd_pkg::ST_MUL;
      end

      plcd_pkg::ST_MUL: begin
        // partial products lo*lo, lo*hi, hi*lo, accumulated from the registered product
        mul_cnt_nxt = mul_cnt_r + 2'd1;
        case (mul_cnt_r)
          2'd0: acc_nxt = acc_r;
          2'd1: acc_nxt = prod_r;
          default: acc_nxt = acc_r + {prod_r[31:0], 32'd0};
        endcase
        if (mul_cnt_r == 2'd3) begin
          state_nxt = plcd_pkg::ST_MIX;
        end
      end

      plcd_pkg::ST_MIX: begin
        lanes_nxt[idx_r] = mixed;
        if (fin_r) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            round_nxt = 1'b1;
          end
          if (idx_r == 2'd3 && round_r) begin
            state_nxt = plcd_pkg::ST_OUT;
          end else begin
            state_nxt = plcd_pkg::ST_FXOR;
          end
        end else begin
          count_nxt = count_r + 64'd1;
          if (last_r) begin
            idx_nxt   = 2'd0;
            round_nxt = 1'b0;
            fin_nxt   = 1'b1;
            state_nxt = plcd_pkg::ST_FXOR;
          end else begin
            state_nxt = plcd_pkg::ST_IDLE;
          end
        end
      end

      plcd_pkg::ST_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          ow_nxt = (idx_r == 2'd0) ? (lane_sel ^ count_r) : lane_sel;
          oi_nxt = idx_r;
          oc_nxt = crc_r;
          ol_nxt = (idx_r == 2'd3);
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            // message done: return to the start state
            lanes_nxt = plcd_pkg::LANE_INIT;
            count_nxt = '0;
            fin_nxt   = 1'b0;
            state_nxt = plcd_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = plcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= plcd_pkg::ST_IDLE;
      lanes_r   <= plcd_pkg::LANE_INIT;
      count_r   <= '0;
      mul_cnt_r <= '0;
      idx_r     <= '0;
      round_r   <= 1'b0;
      fin_r     <= 1'b0;
      last_r    <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      lanes_r   <= lanes_nxt;
      count_r   <= count_nxt;
      mul_cnt_r <= mul_cnt_nxt;
      idx_r     <= idx_nxt;
      round_r   <= round_nxt;
      fin_r     <= fin_nxt;
      last_r    <= last_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
    byte_r <= byte_nxt;
    crc_r  <= crc_nxt;
    ow_r   <= ow_nxt;
    oi_r   <= oi_nxt;
    oc_r   <= oc_nxt;
    ol_r   <= ol_nxt;
  end

endmodule
`default_nettype wire

[bench/payload_crc32_and_lane_digest_tb.sv]
// ----------------------------------------------------------------------------
// payload_crc32_and_lane_digest_tb
// Streams messages byte by byte into the CRC-32 and lane digest block and
// checks every digest word it returns. Expected words are worked out on the
// bench side as each input transfer lands, then compared field by field in
// order. Both channels idle at random.
// ----------------------------------------------------------------------------
module payload_crc32_and_lane_digest_tb;

  localparam logic [31:0] CRC32_POLY   = 32'hEDB88320;
  localparam logic [63:0] LANE_SEED0   = 64'h243F6A8885A308D3;
  localparam logic [63:0] LANE_SEED1   = 64'h13198A2E03707344;
  localparam logic [63:0] LANE_SEED2   = 64'hA4093822299F31D0;
  localparam logic [63:0] LANE_SEED3   = 64'h082EFA98EC4E6C89;
  localparam logic [63:0] SCRAMBLE_ADD = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SCRAMBLE_MUL = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] FOLD_MUL     = 64'hC4CEB9FE1A85EC53;

  localparam int RANDOM_ITEMS = 480;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct {
    logic [63:0] word;
    logic [1:0]  index;
    logic [31:0] crc;
    logic        last_word;
  } digest_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_digest_word;
  logic [1:0]  out_word_index;
  logic [31:0] out_crc_value;
  logic        out_last_word;

  // running message state on the bench side
  logic [31:0] crc_acc;
  logic [63:0] lane_acc [4];
  logic [63:0] msg_len;

  digest_word_t pending_digest_words [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           ready_hold = 0;
  bit           no_input_gaps;

  payload_crc32_and_lane_digest dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_has_byte    (in_has_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digest_word(out_digest_word),
    .out_word_index (out_word_index),
    .out_crc_value  (out_crc_value),
    .out_last_word  (out_last_word)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] crc32_shift_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) r = (r >> 1) ^ CRC32_POLY;
      else      r = r >> 1;
    end
    return r;
  endfunction

  function automatic logic [63:0] lane_scramble(input logic [63:0] lane, input logic [7:0] b);
    logic [63:0] t;
    t = {56'd0, b} + SCRAMBLE_ADD + (lane << 6) + (lane >> 2);
    lane = lane ^ t;
    lane = lane * SCRAMBLE_MUL;
    lane = lane ^ (lane >> 33);
    return lane;
  endfunction

  task automatic clear_message_state();
    crc_acc     = 32'hFFFFFFFF;
    lane_acc[0] = LANE_SEED0;
    lane_acc[1] = LANE_SEED1;
    lane_acc[2] = LANE_SEED2;
    lane_acc[3] = LANE_SEED3;
    msg_len     = 64'd0;
  endtask

  // Absorb one accepted item; on a close, fold the lanes and queue four words.
  task automatic predict_digest_item(input logic [7:0] b, input logic has, input logic lst);
    logic [63:0]  w [4];
    logic [1:0]   sel;
    digest_word_t e;
    if (has) begin
      sel           = msg_len[1:0];
      crc_acc       = crc32_shift_byte(crc_acc, b);
      lane_acc[sel] = lane_scramble(lane_acc[sel], b);
      msg_len       = msg_len + 64'd1;
    end
    if (lst) begin
      for (int k = 0; k < 4; k++) w[k] = lane_acc[k];
      // in place, so lane 3 folds against the already updated lane 0
      for (int r = 0; r < 2; r++) begin
        for (int k = 0; k < 4; k++) begin
          w[k] = w[k] ^ w[(k + 1) % 4];
          w[k] = w[k] * FOLD_MUL;
          w[k] = w[k] ^ (w[k] >> 29);
        end
      end
      w[0] = w[0] ^ msg_len;
      for (int k = 0; k < 4; k++) begin
        e.word      = w[k];
        e.index     = k[1:0];
        e.crc       = ~crc_acc;
        e.last_word = (k == 3);
        pending_digest_words.insert(pending_digest_words.size(), e);
      end
      clear_message_state();
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_input_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one item and hold it until the transfer; valid stays high afterwards
  // so the next call can follow back to back.
  task automatic push_payload_item(input logic [7:0] b, input logic has, input logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_has_byte  <= has;
    in_last      <= lst;
    do @(posedge clk); while (!in_ready);
    predict_digest_item(b, has, lst);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("ERROR %0s: got %h expected %h", what, got, want);
  endtask

  // Result sink: random stalls, mostly short, some long, with ready runs.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_ready  <= 1'b1;
        ready_hold = $urandom_range(0, 6);
      end else if (r < 62) begin
        out_ready  <= 1'b1;
        ready_hold = $urandom_range(20, 60);
      end else if (r < 92) begin
        out_ready  <= 1'b0;
        ready_hold = $urandom_range(0, 3);
      end else begin
        out_ready  <= 1'b0;
        ready_hold = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      digest_word_t want;
      if (pending_digest_words.size() == 0) begin
        report_mismatch("unexpected digest word", out_digest_word, 64'd0);
      end else begin
        want = pending_digest_words.pop_front();
        if (out_digest_word !== want.word)
          report_mismatch("digest_word", out_digest_word, want.word);
        if (out_word_index !== want.index)
          report_mismatch("word_index", {62'd0, out_word_index}, {62'd0, want.index});
        if (out_crc_value !== want.crc)
          report_mismatch("crc_value", {32'd0, out_crc_value}, {32'd0, want.crc});
        if (out_last_word !== want.last_word)
          report_mismatch("last_word", {63'd0, out_last_word}, {63'd0, want.last_word});
      end
    end
  end

  // Close-only items on an empty state, two in a row.
  task automatic test_empty_messages();
    push_payload_item(8'h00, 1'b0, 1'b1);
    push_payload_item(8'hFF, 1'b0, 1'b1);
  endtask

  // Byte extremes, ending with a byte and last in the same transfer.
  task automatic test_byte_extremes();
    push_payload_item(8'h00, 1'b1, 1'b0);
    push_payload_item(8'hFF, 1'b1, 1'b0);
    push_payload_item(8'h80, 1'b1, 1'b0);
    push_payload_item(8'h01, 1'b1, 1'b0);
    push_payload_item(8'h7F, 1'b1, 1'b0);
    push_payload_item(8'hFF, 1'b1, 1'b1);
  endtask

  // Items with no byte and no last must leave the message untouched.
  task automatic test_dropped_items();
    push_payload_item(8'h5A, 1'b0, 1'b0);
    push_payload_item(8'h3C, 1'b1, 1'b0);
    push_payload_item(8'hC3, 1'b0, 1'b0);
    push_payload_item(8'hA5, 1'b1, 1'b1);
  endtask

  // More than one pass over the four lanes, closed by a close-only item.
  task automatic test_lane_wrap();
    for (int i = 0; i < 9; i++) push_payload_item(8'(8'h11 * i), 1'b1, 1'b0);
    push_payload_item(8'hEE, 1'b0, 1'b1);
  endtask

  task automatic test_random_messages();
    int items;
    int len;
    int r;
    bit close_on_byte;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      no_input_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 10)      len = 0;
      else if (r < 88) len = $urandom_range(1, 12);
      else             len = $urandom_range(13, 64);
      close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0)
          push_payload_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        push_payload_item(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (i == len - 1));
        items++;
      end
      if (!close_on_byte) begin
        push_payload_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        items++;
      end
    end
    no_input_gaps = 1'b0;
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data_byte   <= 8'd0;
    in_has_byte    <= 1'b0;
    in_last        <= 1'b0;
    no_input_gaps  = 1'b0;
    clear_message_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_messages();
    test_byte_extremes();
    test_dropped_items();
    test_lane_wrap();
    test_random_messages();

    // drop valid right at the last transfer so it is not taken twice
    in_valid <= 1'b0;
    while (pending_digest_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
